[rtl/lsa_pkg.sv]
package lsa_pkg;

    localparam int BAND_COUNT = 10;
    localparam logic [3:0] BAND_MAX = 4'd9;

    localparam logic [1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LOW_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_BAND   = 2'd2;

    localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'hC000;
    localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'h3FFF;
    localparam logic [3:0]  DEFAULT_BAND_RESET   = 4'd4;

    localparam logic [15:0] CONF_TABLE [BAND_COUNT] = '{
        16'h08C0, 16'h0880, 16'h0840, 16'h0800, 16'h0A00,
        16'h0B00, 16'h0300, 16'h1A00, 16'h1B00, 16'h1300
    };

    localparam logic [19:0] WAIT_TABLE [BAND_COUNT] = '{
        20'd900000, 20'd500000, 20'd250000, 20'd120000, 20'd70000,
        20'd40000,  20'd40000,  20'd70000,  20'd40000,  20'd40000
    };

    // floor(r * (18 << b) / 5) for remainder r of count / 5 and band b
    localparam logic [12:0] FRAC_TABLE [5][BAND_COUNT] = '{
        '{13'd0,  13'd0,  13'd0,  13'd0,   13'd0,
          13'd0,  13'd0,  13'd0,  13'd0,   13'd0},
        '{13'd3,  13'd7,  13'd14, 13'd28,  13'd57,
          13'd115, 13'd230, 13'd460, 13'd921, 13'd1843},
        '{13'd7,  13'd14, 13'd28, 13'd57,  13'd115,
          13'd230, 13'd460, 13'd921, 13'd1843, 13'd3686},
        '{13'd10, 13'd21, 13'd43, 13'd86,  13'd172,
          13'd345, 13'd691, 13'd1382, 13'd2764, 13'd5529},
        '{13'd14, 13'd28, 13'd57, 13'd115, 13'd230,
          13'd460, 13'd921, 13'd1843, 13'd3686, 13'd7372}
    };

    typedef struct packed {
        logic [15:0] light_count;
        logic [15:0] white_count;
    } item_t;

    typedef struct packed {
        logic [3:0]  band_used;
        logic [15:0] conf_word;
        logic [26:0] lux_millilux;
        logic [3:0]  next_band;
        logic [15:0] next_conf_word;
        logic [19:0] next_wait_us;
    } result_t;

endpackage

[rtl/light_sensor_autorange_top.sv]
// Channel   Handshake                  Payload
// item      item_valid / item_ready    item (light_count, white_count)
// result    result_valid / result_ready result (bands, conf words, lux, wait)
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One transfer per cycle on item and result while result_ready is high; each
// item passes the input register, then the result register.
// The band feedback closes in the single stage between the two registers.
// Reset clears band history, thresholds and default band to their defaults.
// A stalled result holds; the input register still takes one item behind it.
// cfg_ready is always high; writes go straight into the config registers.
module light_sensor_autorange_top
    import lsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        item_valid_reg;
    item_t       item_reg;
    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic [3:0]  band_reg;
    logic [3:0]  band_next;
    logic        band_valid_reg;
    logic [15:0] high_threshold_reg;
    logic [15:0] low_threshold_reg;
    logic [3:0]  default_band_reg;

    logic        stage_fire;
    logic        item_fire;
    logic [3:0]  band_cur;
    logic [3:0]  default_clamped;
    logic [15:0] peak;
    logic [26:0] lux;

    assign stage_fire   = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || stage_fire;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    lsa_lux u_lux (
        .light_count  (item_reg.light_count),
        .band         (band_cur),
        .lux_millilux (lux)
    );

    always_comb
    begin
        default_clamped = (default_band_reg > BAND_MAX) ? BAND_MAX : default_band_reg;
        if (!band_valid_reg || band_reg > BAND_MAX)
            band_cur = default_clamped;
        else
            band_cur = band_reg;

        peak = (item_reg.white_count > item_reg.light_count) ?
               item_reg.white_count : item_reg.light_count;

        band_next = band_cur;
        if (peak >= high_threshold_reg)
        begin
            if (band_cur < BAND_MAX)
                band_next = band_cur + 4'd1;
        end
        else if (peak <= low_threshold_reg)
        begin
            if (band_cur != 4'd0)
                band_next = band_cur - 4'd1;
        end

        result_next.band_used      = band_cur;
        result_next.conf_word      = CONF_TABLE[band_cur];
        result_next.lux_millilux   = lux;
        result_next.next_band      = band_next;
        result_next.next_conf_word = CONF_TABLE[band_next];
        result_next.next_wait_us   = WAIT_TABLE[band_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
            band_reg           <= 4'd0;
            band_valid_reg     <= 1'b0;
            high_threshold_reg <= HIGH_THRESHOLD_RESET;
            low_threshold_reg  <= LOW_THRESHOLD_RESET;
            default_band_reg   <= DEFAULT_BAND_RESET;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (stage_fire)
            begin
                result_valid_reg <= 1'b1;
                band_reg         <= band_next;
                band_valid_reg   <= 1'b1;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data;
                    CFG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data;
                    CFG_DEFAULT_BAND:   default_band_reg   <= cfg_data[3:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            item_reg <= item;
        if (stage_fire)
            result_reg <= result_next;
    end

    a_band_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_valid_reg |-> band_reg <= BAND_MAX)
        else $error("stored band out of range");

    a_band_follows: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> (band_valid_reg && band_reg == result_reg.next_band))
        else $error("stored band does not match last result");

    a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.next_band == result_reg.band_used ||
                              result_reg.next_band == result_reg.band_used + 4'd1 ||
                              result_reg.next_band == result_reg.band_used - 4'd1))
        else $error("band moved more than one step");

    a_lux_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.lux_millilux != 27'd0)
        else $error("lux not clamped");

endmodule

[rtl/lsa_lux.sv]
module lsa_lux
    import lsa_pkg::*;
(
    input  logic [15:0] light_count,
    input  logic [3:0]  band,
    output logic [26:0] lux_millilux
);

    logic [31:0] recip_prod;
    logic [13:0] quot5;
    logic [15:0] quot5_x5;
    logic [15:0] rem_full;
    logic [2:0]  rem5;
    logic [17:0] base;
    logic [26:0] shifted;
    logic [26:0] total;

    // count = 5 * quot5 + rem5, so lux = (quot5 * 18 << band) + table term
    always_comb
    begin
        recip_prod = 32'(light_count) * 32'd52429;
        quot5      = recip_prod[31:18];
        quot5_x5   = (16'(quot5) << 2) + 16'(quot5);
        rem_full   = light_count - quot5_x5;
        rem5       = rem_full[2:0];
        base       = (18'(quot5) << 4) + (18'(quot5) << 1);
        shifted    = 27'(base) << band;
        total      = shifted + 27'(FRAC_TABLE[rem5][band]);
        lux_millilux = (total == 27'd0) ? 27'd1 : total;
    end

endmodule
